[src/spi_flash_fifo_chip_select_core_defines.svh]
// Assertion helpers for the checker file.
`ifndef SPI_FLASH_FIFO_CHIP_SELECT_CORE_DEFINES_SVH
`define SPI_FLASH_FIFO_CHIP_SELECT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SFCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfcs check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SFCS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfcs check failed");

`endif

[src/sfcs_pkg.sv]
package sfcs_pkg;

    localparam int FIFO_DEPTH  = 256;
    localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int CHIP_COUNT  = 4;
    localparam int CHIP_W      = $clog2(CHIP_COUNT);
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register map
    localparam logic [IDX_W-1:0] REG_STATE = 3'd0;
    localparam logic [IDX_W-1:0] REG_CTRL1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_CTRL2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_RXBUF = 3'd3;
    localparam logic [IDX_W-1:0] REG_TXBUF = 3'd4;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Chip bits inside a control write
    localparam int SEL_LO_BIT = 0;
    localparam int SEL_HI_BIT = 8;

    typedef enum logic [2:0] {
        OP_ZERO,     // read returning zero, or ignored write
        OP_CTRL_RD,
        OP_RX_RD,
        OP_TX_WR,
        OP_CTRL_WR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              bank;    // 0: chips 0/1, 1: chips 2/3
        logic [BYTE_W-1:0] tx_byte;
        logic              sel_lo;
        logic              sel_hi;
    } t_cmd;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

endpackage

[src/sfcs_front.sv]
module sfcs_front (
    input  logic                        i_start,
    input  logic                        i_mode,
    input  logic [sfcs_pkg::IDX_W-1:0]  i_reg_index,
    input  logic [sfcs_pkg::DATA_W-1:0] i_write_data,
    input  logic                        i_q_full,
    output logic                        o_busy,
    output logic                        o_push,
    output sfcs_pkg::t_cmd              o_cmd
);
    import sfcs_pkg::*;

    t_cmd cmd;

    // Classify the access into one back-end operation
    always_comb begin
        cmd         = '0;
        cmd.op      = OP_ZERO;
        cmd.bank    = (i_reg_index == REG_CTRL2);
        cmd.tx_byte = i_write_data[BYTE_W-1:0];
        cmd.sel_lo  = i_write_data[SEL_LO_BIT];
        cmd.sel_hi  = i_write_data[SEL_HI_BIT];
        if (i_mode == MODE_WRITE) begin
            unique case (i_reg_index) inside
                REG_CTRL1, REG_CTRL2: cmd.op = OP_CTRL_WR;
                REG_TXBUF:            cmd.op = OP_TX_WR;
                default:              cmd.op = OP_ZERO;
            endcase
        end else begin
            unique case (i_reg_index) inside
                REG_CTRL1, REG_CTRL2: cmd.op = OP_CTRL_RD;
                REG_RXBUF:            cmd.op = OP_RX_RD;
                default:              cmd.op = OP_ZERO;
            endcase
        end
    end

    assign o_busy = i_q_full;
    assign o_push = i_start && !i_q_full;
    assign o_cmd  = cmd;

endmodule

[src/sfcs_cmd_queue.sv]
module sfcs_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfcs_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output sfcs_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);
    import sfcs_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/sfcs_back.sv]
module sfcs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  sfcs_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    output logic                          o_done,
    output logic [sfcs_pkg::DATA_W-1:0]   o_read_data,
    output logic [sfcs_pkg::CHIP_COUNT-1:0] o_chip_select_n,
    output logic                          o_tx_dropped,
    output logic                          o_rx_underflow
);
    import sfcs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LB_CHK,
        S_LB_WR,
        S_RX_RD
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [PTR_W-1:0]  r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [CNT_W-1:0]  r_tx_count, n_tx_count;
    logic [PTR_W-1:0]  r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [CNT_W-1:0]  r_rx_count, n_rx_count;
    logic [CHIP_W-1:0] r_sel_chip, n_sel_chip;
    logic [CHIP_COUNT-1:0] r_cs_n, n_cs_n;
    logic              r_done, n_done;
    logic [DATA_W-1:0] r_read_data, n_read_data;
    logic              r_tx_dropped, n_tx_dropped;
    logic              r_rx_underflow, n_rx_underflow;

    logic [BYTE_W-1:0] r_tx_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] r_rx_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] r_tx_rdata, r_rx_rdata;
    logic              tx_we, rx_we;

    logic              tx_empty, tx_full, rx_empty, rx_full;
    logic [CHIP_W-1:0] chip;

    assign tx_empty = (r_tx_count == '0);
    assign tx_full  = (r_tx_count == CNT_W'(FIFO_DEPTH));
    assign rx_empty = (r_rx_count == '0);
    assign rx_full  = (r_rx_count == CNT_W'(FIFO_DEPTH));
    assign chip     = {r_cmd.bank, !r_cmd.sel_lo};

    // Byte stores: one write port, registered read of the head entry
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_tail] <= i_cmd.tx_byte;
        end
        r_tx_rdata <= r_tx_mem[r_tx_head];
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[r_rx_tail] <= r_tx_rdata;
        end
        r_rx_rdata <= r_rx_mem[r_rx_head];
    end

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_tx_head      = r_tx_head;
        n_tx_tail      = r_tx_tail;
        n_tx_count     = r_tx_count;
        n_rx_head      = r_rx_head;
        n_rx_tail      = r_rx_tail;
        n_rx_count     = r_rx_count;
        n_sel_chip     = r_sel_chip;
        n_cs_n         = r_cs_n;
        n_done         = 1'b0;
        n_read_data    = '0;
        n_tx_dropped   = 1'b0;
        n_rx_underflow = 1'b0;
        o_pop          = 1'b0;
        tx_we          = 1'b0;
        rx_we          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        OP_CTRL_RD: begin
                            n_done                  = 1'b1;
                            n_read_data[SEL_LO_BIT] = (r_sel_chip == {i_cmd.bank, 1'b0});
                            n_read_data[SEL_HI_BIT] = (r_sel_chip == {i_cmd.bank, 1'b1});
                        end
                        OP_TX_WR: begin
                            n_done = 1'b1;
                            if (tx_full) begin
                                n_tx_dropped = 1'b1;
                            end else begin
                                tx_we      = 1'b1;
                                n_tx_tail  = ptr_next(r_tx_tail);
                                n_tx_count = r_tx_count + CNT_W'(1);
                            end
                        end
                        OP_RX_RD: begin
                            if (rx_empty) begin
                                n_done         = 1'b1;
                                n_rx_underflow = 1'b1;
                            end else begin
                                n_state = S_RX_RD;
                            end
                        end
                        OP_CTRL_WR: n_state = S_LB_CHK;
                        default:    n_done  = 1'b1;
                    endcase
                end
            end
            S_RX_RD: begin
                n_done      = 1'b1;
                n_read_data = DATA_W'(r_rx_rdata);
                n_rx_head   = ptr_next(r_rx_head);
                n_rx_count  = r_rx_count - CNT_W'(1);
                n_state     = S_IDLE;
            end
            S_LB_CHK: begin
                if (tx_empty || rx_full) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd.sel_lo || r_cmd.sel_hi) begin
                        n_sel_chip = chip;
                        n_cs_n     = ~(CHIP_COUNT'(1) << chip);
                    end
                end else begin
                    n_state = S_LB_WR;
                end
            end
            S_LB_WR: begin
                rx_we      = 1'b1;
                n_tx_head  = ptr_next(r_tx_head);
                n_tx_count = r_tx_count - CNT_W'(1);
                n_rx_tail  = ptr_next(r_rx_tail);
                n_rx_count = r_rx_count + CNT_W'(1);
                n_state    = S_LB_CHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tx_head      <= '0;
            r_tx_tail      <= '0;
            r_tx_count     <= '0;
            r_rx_head      <= '0;
            r_rx_tail      <= '0;
            r_rx_count     <= '0;
            r_sel_chip     <= '0;
            r_cs_n         <= '1;
            r_done         <= 1'b0;
            r_tx_dropped   <= 1'b0;
            r_rx_underflow <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_tx_head      <= n_tx_head;
            r_tx_tail      <= n_tx_tail;
            r_tx_count     <= n_tx_count;
            r_rx_head      <= n_rx_head;
            r_rx_tail      <= n_rx_tail;
            r_rx_count     <= n_rx_count;
            r_sel_chip     <= n_sel_chip;
            r_cs_n         <= n_cs_n;
            r_done         <= n_done;
            r_tx_dropped   <= n_tx_dropped;
            r_rx_underflow <= n_rx_underflow;
        end
        r_cmd       <= n_cmd;
        r_read_data <= n_read_data;
    end

    assign o_done          = r_done;
    assign o_read_data     = r_read_data;
    assign o_chip_select_n = r_cs_n;
    assign o_tx_dropped    = r_tx_dropped;
    assign o_rx_underflow  = r_rx_underflow;

endmodule

[src/spi_flash_fifo_chip_select_core.sv]
// An accepted access passes through the command queue to the back end, whose result
// strobe is registered; a receive-buffer read first passes S_RX_RD, and a control write
// first loops back N bytes (N <= FIFO_DEPTH). The back end takes one access at a time;
// its loopback moves each byte through S_LB_CHK and then S_LB_WR (registered store read, then write).
// A two-entry command queue lets start be taken while the back end works; the receiver
// cannot stall. Synchronous active-low reset empties both FIFOs and raises all selects.
module spi_flash_fifo_chip_select_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [sfcs_pkg::IDX_W-1:0]      i_reg_index,
    input  logic [sfcs_pkg::DATA_W-1:0]     i_write_data,
    output logic                            o_done,
    output logic [sfcs_pkg::DATA_W-1:0]     o_read_data,
    output logic [sfcs_pkg::CHIP_COUNT-1:0] o_chip_select_n,
    output logic                            o_tx_dropped,
    output logic                            o_rx_underflow
);
    import sfcs_pkg::*;

    // Front end to queue
    logic q_push;
    t_cmd push_cmd;
    logic q_full;

    // Queue to back end
    logic q_pop;
    logic q_empty;
    t_cmd head_cmd;

    // Front end: decodes one register access into an operation and pushes it.
    // busy follows the queue being full, so a transfer is taken whenever there is room.
    sfcs_front u_front (
        .i_start      (start),
        .i_mode       (i_mode),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .i_q_full     (q_full),
        .o_busy       (busy),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    // Short command queue decoupling the two halves
    sfcs_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back end: owns both byte FIFOs, the loopback sequencer and the chip-select
    // state, and drives every result from registers.
    sfcs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (head_cmd),
        .o_pop           (q_pop),
        .o_done          (o_done),
        .o_read_data     (o_read_data),
        .o_chip_select_n (o_chip_select_n),
        .o_tx_dropped    (o_tx_dropped),
        .o_rx_underflow  (o_rx_underflow)
    );

endmodule

[src/sfcs_checker.sv]
`include "spi_flash_fifo_chip_select_core_defines.svh"

module sfcs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_done,
    input logic [sfcs_pkg::DATA_W-1:0]     o_read_data,
    input logic [sfcs_pkg::CHIP_COUNT-1:0] o_chip_select_n,
    input logic                            o_tx_dropped,
    input logic                            o_rx_underflow
);
    // At most one chip is ever selected
    `SFCS_ASSERT_IMP(a_cs_onehot, 1'b1, $onehot0(~o_chip_select_n))
    // Select lines only move together with a result
    `SFCS_ASSERT_IMP(a_cs_moves_with_done, !$stable(o_chip_select_n), o_done)
    // An underflowing read returns zero and never carries a drop
    `SFCS_ASSERT_IMP(a_underflow_zero, o_done && o_rx_underflow,
                     o_read_data == '0 && !o_tx_dropped)
    // A control write ends only after a loopback check, so select lines never change straight after a result
    `SFCS_ASSERT_NXT(a_cs_settled_after_done, o_done, $stable(o_chip_select_n))
endmodule

bind spi_flash_fifo_chip_select_core sfcs_checker u_sfcs_checker (.*);

[verif/tb_spi_flash_fifo_chip_select_core.sv]
`timescale 1ns / 1ps

module tb_spi_flash_fifo_chip_select_core;
    import sfcs_pkg::*;

    // Index with no register behind it: reads give 0, writes are dropped
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd5;

    // A full loopback moves FIFO_DEPTH bytes; leave ample margin
    localparam int LOOPBACK_CYCLES = 2 * FIFO_DEPTH + 16;
    localparam int WATCHDOG_LIMIT  = 8 * LOOPBACK_CYCLES;
    localparam int RANDOM_ACCESSES = 700;
    localparam int DIRECTED_ROWS   = 27;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        logic [CHIP_COUNT-1:0] cs_n;
        logic                  dropped;
        logic                  underflow;
    } access_result_t;

    // One directed access; 'typed' rows carry their expected result, the rest
    // are left to the predictor
    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic              typed;
        access_result_t    want;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // straight out of reset: nothing selected, both FIFOs empty
        '{MODE_READ,  REG_STATE,    32'h0000_0000, 1'b1, '{32'h0,   4'hF, 1'b0, 1'b0}},
        // ctrl1 claims chip 0 though every line is still high
        '{MODE_READ,  REG_CTRL1,    32'h0000_0000, 1'b1, '{32'h1,   4'hF, 1'b0, 1'b0}},
        '{MODE_READ,  REG_CTRL2,    32'hFFFF_FFFF, 1'b1, '{32'h0,   4'hF, 1'b0, 1'b0}},
        '{MODE_READ,  REG_RXBUF,    32'h0000_0000, 1'b1, '{32'h0,   4'hF, 1'b0, 1'b1}},
        '{MODE_READ,  REG_TXBUF,    32'h0000_0000, 1'b1, '{32'h0,   4'hF, 1'b0, 1'b0}},
        '{MODE_READ,  REG_UNMAPPED, 32'h0000_0000, 1'b1, '{32'h0,   4'hF, 1'b0, 1'b0}},
        // no chip bit: loopback only, lines untouched
        '{MODE_WRITE, REG_CTRL1,    32'h0000_0000, 1'b1, '{32'h0,   4'hF, 1'b0, 1'b0}},
        // both chip bits: the bit-0 chip wins
        '{MODE_WRITE, REG_CTRL2,    32'h0000_0101, 1'b1, '{32'h0,   4'hB, 1'b0, 1'b0}},
        '{MODE_READ,  REG_CTRL2,    32'h0000_0000, 1'b1, '{32'h1,   4'hB, 1'b0, 1'b0}},
        '{MODE_READ,  REG_CTRL1,    32'h0000_0000, 1'b1, '{32'h0,   4'hB, 1'b0, 1'b0}},
        '{MODE_WRITE, REG_CTRL2,    32'h0000_0100, 1'b1, '{32'h0,   4'h7, 1'b0, 1'b0}},
        '{MODE_READ,  REG_CTRL2,    32'h0000_0000, 1'b1, '{32'h100, 4'h7, 1'b0, 1'b0}},
        '{MODE_WRITE, REG_CTRL1,    32'hFFFF_FFFF, 1'b1, '{32'h0,   4'hE, 1'b0, 1'b0}},
        '{MODE_WRITE, REG_CTRL1,    32'hFFFF_FFFE, 1'b1, '{32'h0,   4'hD, 1'b0, 1'b0}},
        '{MODE_READ,  REG_CTRL1,    32'h0000_0000, 1'b1, '{32'h100, 4'hD, 1'b0, 1'b0}},
        // three bytes queued for transmit
        '{MODE_WRITE, REG_TXBUF,    32'hFFFF_FFFF, 1'b1, '{32'h0,   4'hD, 1'b0, 1'b0}},
        '{MODE_WRITE, REG_TXBUF,    32'h0000_0000, 1'b1, '{32'h0,   4'hD, 1'b0, 1'b0}},
        '{MODE_WRITE, REG_TXBUF,    32'h5A3C_96A5, 1'b0, '0},
        // writes with nowhere to go
        '{MODE_WRITE, REG_STATE,    32'hFFFF_FFFF, 1'b1, '{32'h0,   4'hD, 1'b0, 1'b0}},
        '{MODE_WRITE, REG_RXBUF,    32'hFFFF_FFFF, 1'b1, '{32'h0,   4'hD, 1'b0, 1'b0}},
        '{MODE_WRITE, REG_UNMAPPED, 32'hFFFF_FFFF, 1'b1, '{32'h0,   4'hD, 1'b0, 1'b0}},
        // bytes still sit in transmit, so receive is empty
        '{MODE_READ,  REG_RXBUF,    32'h0000_0000, 1'b1, '{32'h0,   4'hD, 1'b0, 1'b1}},
        // loopback, then chip 3 via the high bit
        '{MODE_WRITE, REG_CTRL2,    32'hFFFF_FFFE, 1'b0, '0},
        '{MODE_READ,  REG_RXBUF,    32'h0000_0000, 1'b1, '{32'hFF,  4'h7, 1'b0, 1'b0}},
        '{MODE_READ,  REG_RXBUF,    32'h0000_0000, 1'b1, '{32'h0,   4'h7, 1'b0, 1'b0}},
        '{MODE_READ,  REG_RXBUF,    32'h0000_0000, 1'b0, '0},
        '{MODE_READ,  REG_RXBUF,    32'h0000_0000, 1'b1, '{32'h0,   4'h7, 1'b0, 1'b1}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_mode;
    logic [IDX_W-1:0]  i_reg_index;
    logic [DATA_W-1:0] i_write_data;
    logic              o_done;
    logic [DATA_W-1:0] o_read_data;
    logic [CHIP_COUNT-1:0] o_chip_select_n;
    logic              o_tx_dropped;
    logic              o_rx_underflow;

    spi_flash_fifo_chip_select_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_reg_index     (i_reg_index),
        .i_write_data    (i_write_data),
        .o_done          (o_done),
        .o_read_data     (o_read_data),
        .o_chip_select_n (o_chip_select_n),
        .o_tx_dropped    (o_tx_dropped),
        .o_rx_underflow  (o_rx_underflow)
    );

    // Predicted block state: loopback FIFOs as byte queues plus the selection
    logic [BYTE_W-1:0]     tx_bytes [$];
    logic [BYTE_W-1:0]     rx_bytes [$];
    logic [CHIP_W-1:0]     sel_chip;
    logic [CHIP_COUNT-1:0] sel_lines;

    access_result_t pending_results [$];

    int  mismatch_count;
    int  results_checked;
    int  dropped_seen;
    int  underflow_seen;
    int  accesses_sent;
    int  stall_cycles;
    bit  steady;    // no sender gaps while set

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the result of one access and advances the predicted state
    task automatic predict_access(input logic mode, input logic [IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] data,
                                  output access_result_t res);
        logic [CHIP_W-1:0] base;
        res  = '0;
        base = (idx == REG_CTRL2) ? CHIP_W'(2) : CHIP_W'(0);
        if (mode == MODE_WRITE) begin
            case (idx)
                REG_CTRL1, REG_CTRL2: begin
                    // loopback stands in for the serial transfer
                    while (tx_bytes.size() != 0 && rx_bytes.size() < FIFO_DEPTH)
                        rx_bytes.push_back(tx_bytes.pop_front());
                    if (data[SEL_LO_BIT] || data[SEL_HI_BIT]) begin
                        sel_chip  = base + (data[SEL_LO_BIT] ? CHIP_W'(0) : CHIP_W'(1));
                        sel_lines = ~(CHIP_COUNT'(1) << sel_chip);
                    end
                end
                REG_TXBUF: begin
                    if (tx_bytes.size() < FIFO_DEPTH)
                        tx_bytes.push_back(data[BYTE_W-1:0]);
                    else
                        res.dropped = 1'b1;
                end
                default: ;
            endcase
        end else begin
            case (idx)
                REG_CTRL1, REG_CTRL2: begin
                    res.read_data[SEL_LO_BIT] = (sel_chip == base);
                    res.read_data[SEL_HI_BIT] = (sel_chip == base + CHIP_W'(1));
                end
                REG_RXBUF: begin
                    if (rx_bytes.size() != 0)
                        res.read_data = DATA_W'(rx_bytes.pop_front());
                    else
                        res.underflow = 1'b1;
                end
                default: ;
            endcase
        end
        res.cs_n = sel_lines;
    endtask

    // Presents one access from a falling edge and returns at the falling edge
    // after its transfer; start stays high when the next access follows at once
    task automatic issue_access(input logic mode, input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data,
                                input logic typed, input access_result_t want);
        access_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 31) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_reg_index  <= idx;
        i_write_data <= data;
        do @(posedge i_clk); while (busy);
        predict_access(mode, idx, data, predicted);
        pending_results.push_back(typed ? want : predicted);
        if (!(mode == MODE_WRITE && idx != REG_CTRL1 && idx != REG_CTRL2 && idx != REG_TXBUF))
            accesses_sent++;
        @(negedge i_clk);
    endtask

    task automatic send(input logic mode, input logic [IDX_W-1:0] idx,
                        input logic [DATA_W-1:0] data);
        issue_access(mode, idx, data, 1'b0, '0);
    endtask

    // Random control write; the chip bits get all four combinations
    task automatic send_ctrl_write();
        logic [DATA_W-1:0] data;
        logic [1:0]        pick;
        data = $urandom();
        pick = 2'($urandom_range(0, 3));
        data[SEL_LO_BIT] = pick[0];
        data[SEL_HI_BIT] = pick[1];
        send(MODE_WRITE, $urandom_range(0, 1) ? REG_CTRL2 : REG_CTRL1, data);
    endtask

    // Overfill transmit so one to three bytes are dropped, then loop the rest back
    task automatic fill_and_loop();
        int burst;
        burst = FIFO_DEPTH - tx_bytes.size() + $urandom_range(1, 3);
        repeat (burst) send(MODE_WRITE, REG_TXBUF, $urandom());
        send_ctrl_write();
    endtask

    // Sender holds off until every outstanding result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // Result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        access_result_t exp_res;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: read_data %h cs_n %h",
                         $time, o_read_data, o_chip_select_n);
                $display("%0t: dropped %b underflow %b",
                         $time, o_tx_dropped, o_rx_underflow);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (o_tx_dropped)   dropped_seen++;
                if (o_rx_underflow) underflow_seen++;
                if (o_read_data !== exp_res.read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, exp_res.read_data, o_read_data);
                    mismatch_count++;
                end
                if (o_chip_select_n !== exp_res.cs_n) begin
                    $display("%0t: chip_select_n expected %h actual %h",
                             $time, exp_res.cs_n, o_chip_select_n);
                    mismatch_count++;
                end
                if (o_tx_dropped !== exp_res.dropped) begin
                    $display("%0t: tx_dropped expected %b actual %b",
                             $time, exp_res.dropped, o_tx_dropped);
                    mismatch_count++;
                end
                if (o_rx_underflow !== exp_res.underflow) begin
                    $display("%0t: rx_underflow expected %b actual %b",
                             $time, exp_res.underflow, o_rx_underflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long with neither a transfer nor a result means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int kind;
        int burst;
        int target;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = MODE_READ;
        i_reg_index  = REG_STATE;
        i_write_data = '0;
        steady       = 1'b0;
        mismatch_count  = 0;
        results_checked = 0;
        dropped_seen    = 0;
        underflow_seen  = 0;
        accesses_sent   = 0;
        stall_cycles    = 0;
        sel_chip  = '0;
        sel_lines = '1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed accesses: register map corners, chip-bit cases, empty receive
        for (int k = 0; k < DIRECTED_ROWS; k++)
            issue_access(DIRECTED[k].mode, DIRECTED[k].idx, DIRECTED[k].data,
                         DIRECTED[k].typed, DIRECTED[k].want);

        // Let the block drain completely before the random phase
        wait_for_results();

        // Start the random phase with a full transmit FIFO so receive ends up
        // full and a later loopback finds no room
        fill_and_loop();

        target = accesses_sent + RANDOM_ACCESSES;
        while (accesses_sent < target) begin
            // a stretch in the middle runs back to back
            steady = (accesses_sent >= target - 600) && (accesses_sent < target - 450);
            kind   = $urandom_range(0, 99);
            if (kind < 30) begin
                burst = $urandom_range(1, 16);
                repeat (burst) send(MODE_WRITE, REG_TXBUF, $urandom());
            end else if (kind < 48) begin
                send_ctrl_write();
            end else if (kind < 73) begin
                burst = $urandom_range(1, 16);
                repeat (burst) send(MODE_READ, REG_RXBUF, $urandom());
            end else if (kind < 83) begin
                send(MODE_READ, $urandom_range(0, 1) ? REG_CTRL2 : REG_CTRL1, $urandom());
            end else if (kind < 95) begin
                // noise: any access kind at indices 0 to 5
                send(logic'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 5)), $urandom());
            end else if (kind < 97) begin
                fill_and_loop();
            end else begin
                // empty the receive FIFO and read past its end
                burst = rx_bytes.size() + $urandom_range(0, 2);
                repeat (burst) send(MODE_READ, REG_RXBUF, $urandom());
            end
            if ($urandom_range(0, 99) < 2)
                wait_for_results();
        end
        steady = 1'b0;

        wait_for_results();
        repeat (LOOPBACK_CYCLES) @(posedge i_clk);

        $display("Checked %0d results over %0d accesses to the register map,",
                 results_checked, accesses_sent);
        $display("including %0d dropped transmit writes and %0d reads of an empty receive FIFO.",
                 dropped_seen, underflow_seen);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
